>>> src/qbs_pkg.sv
`default_nettype none

package qbs_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 4096;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 12;
  localparam int MEAN_W   = 16;
  localparam int RMS_W    = 15;
  localparam int POWER_W  = 27;
  localparam int COUNT_W  = 13;

  // square of a sample is at most 2^30
  localparam int SQ_W       = 31;
  localparam int TERM_SHIFT = 15;
  localparam int TERM_W     = 15;

  // bit-pair square root over a 32-bit radicand
  localparam int RAD_W      = 32;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SREM_W     = ROOT_W + 3;
  localparam int SQRT_STEPS = RAD_W / 2;

  function automatic int qbs_cnt_w(input int unsigned max_samples);
    return $clog2(max_samples + 1);
  endfunction

  // dividend width of the shared divider, wide enough for the square sum
  function automatic int qbs_div_w(input int unsigned max_samples);
    return SQ_W - 1 + qbs_cnt_w(max_samples);
  endfunction

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] min_value;
    logic [IDX_W-1:0]           min_index;
    logic signed [SAMPLE_W-1:0] max_value;
    logic [IDX_W-1:0]           max_index;
    logic signed [MEAN_W-1:0]   mean;
    logic [RMS_W-1:0]           rms;
    logic [POWER_W-1:0]         power;
    logic [COUNT_W-1:0]         sample_count;
    logic                       too_long;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_MEAN_DIV,
    ST_MS_LOAD,
    ST_MS_DIV,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic acc_en;
    logic load_mean;
    logic div_step;
    logic load_ms;
    logic load_root;
    logic root_step;
    logic out_load;
  } cmd_t;

endpackage

`default_nettype wire

>>> src/qbs_stream_if.sv
`default_nettype none

interface qbs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> src/qbs_ctrl.sv
`default_nettype none

module qbs_ctrl
  import qbs_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  localparam int DIV_W  = qbs_div_w(MAX_SAMPLES);
  localparam int STEP_W = $clog2(DIV_W);
  localparam logic [STEP_W-1:0] DivLast  = STEP_W'(DIV_W - 1);
  localparam logic [STEP_W-1:0] RootLast = STEP_W'(SQRT_STEPS - 1);

  st_e               state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACCUM:     if (in_valid_i && in_last_i) state_d = ST_FLUSH;
      ST_FLUSH:     state_d = ST_MEAN_DIV;
      ST_MEAN_DIV:  if (step_q == DivLast) state_d = ST_MS_LOAD;
      ST_MS_LOAD:   state_d = ST_MS_DIV;
      ST_MS_DIV:    if (step_q == DivLast) state_d = ST_ROOT_LOAD;
      ST_ROOT_LOAD: state_d = ST_ROOT;
      ST_ROOT:      if (step_q == RootLast) state_d = ST_DONE;
      ST_DONE:      if (out_free) state_d = ST_ACCUM;
      default:      state_d = ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_ACCUM: begin
        in_ready_o   = 1'b1;
        cmd_o.acc_en = in_valid_i;
      end
      ST_FLUSH:     cmd_o.load_mean = 1'b1;
      ST_MEAN_DIV:  cmd_o.div_step  = 1'b1;
      ST_MS_LOAD:   cmd_o.load_ms   = 1'b1;
      ST_MS_DIV:    cmd_o.div_step  = 1'b1;
      ST_ROOT_LOAD: cmd_o.load_root = 1'b1;
      ST_ROOT:      cmd_o.root_step = 1'b1;
      ST_DONE:      cmd_o.out_load  = out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  // iteration counter, shared by divider and square root
  always_comb begin
    step_d = '0;
    if (cmd_o.div_step || cmd_o.root_step) begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> src/qbs_datapath.sv
`default_nettype none

module qbs_datapath
  import qbs_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  in_item_t  in_item_i,
  output out_item_t out_item_o
);

  localparam int CNT_W = qbs_cnt_w(MAX_SAMPLES);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int PWR_W = TERM_W + CNT_W;
  localparam int DIV_W = qbs_div_w(MAX_SAMPLES);
  localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_SAMPLES);

  // accumulators
  logic [CNT_W-1:0]           count_q;
  logic signed [SAMPLE_W-1:0] low_q, high_q;
  logic [IDX_W-1:0]           low_idx_q, high_idx_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic [DIV_W-1:0]           sq_acc_q;
  logic [PWR_W-1:0]           pwr_q;
  logic                       ovf_q;
  logic [SQ_W-1:0]            sq_q;
  logic                       sq_vld_q;

  // divider and square root
  logic [CNT_W-1:0]         rem_q;
  logic [DIV_W-1:0]         quo_q;
  logic                     neg_q;
  logic signed [MEAN_W-1:0] mean_q;
  logic [RAD_W-1:0]         x_q;
  logic [SREM_W-1:0]        srem_q;
  logic [ROOT_W-1:0]        root_q;
  out_item_t                out_q;

  logic signed [SAMPLE_W-1:0]   s;
  logic                         counting, take;
  logic [IDX_W-1:0]             pos;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic [SQ_W-TERM_SHIFT-1:0]   term;
  logic [TERM_W-1:0]            term_sat;
  logic [SUM_W-1:0]             sum_mag;
  logic [CNT_W:0]               trial, divisor;
  logic                         qbit;
  logic [CNT_W-1:0]             rem_d;
  logic [MEAN_W-1:0]            mag;
  logic [SREM_W-1:0]            srem_sh, rtrial, srem_d;
  logic                         rbit;

  assign s        = in_item_i.sample;
  assign counting = count_q < MaxCount;
  assign take     = cmd_i.acc_en && counting;
  assign pos      = IDX_W'(count_q);
  assign prod     = s * s;

  // q15 power term, saturates only for the full-scale negative sample
  assign term     = sq_q[SQ_W-1:TERM_SHIFT];
  assign term_sat = term[TERM_W] ? '1 : term[TERM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      low_q      <= '0;
      low_idx_q  <= '0;
      high_q     <= '0;
      high_idx_q <= '0;
      sum_q      <= '0;
      sq_acc_q   <= '0;
      pwr_q      <= '0;
      ovf_q      <= 1'b0;
      sq_vld_q   <= 1'b0;
    end else if (cmd_i.out_load) begin
      count_q    <= '0;
      low_q      <= '0;
      low_idx_q  <= '0;
      high_q     <= '0;
      high_idx_q <= '0;
      sum_q      <= '0;
      sq_acc_q   <= '0;
      pwr_q      <= '0;
      ovf_q      <= 1'b0;
      sq_vld_q   <= 1'b0;
    end else begin
      if (take) begin
        count_q <= count_q + CNT_W'(1);
        if (count_q == '0 || s < low_q) begin
          low_q     <= s;
          low_idx_q <= pos;
        end
        if (count_q == '0 || s > high_q) begin
          high_q     <= s;
          high_idx_q <= pos;
        end
        sum_q <= sum_q + SUM_W'(s);
      end
      if (cmd_i.acc_en && !counting) begin
        ovf_q <= 1'b1;
      end
      // the square lands in the cycle after its sample
      sq_vld_q <= take;
      if (sq_vld_q) begin
        sq_acc_q <= sq_acc_q + DIV_W'(sq_q);
        pwr_q    <= pwr_q + PWR_W'(term_sat);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sq_q <= SQ_W'(prod);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign divisor = {1'b0, count_q};
  assign trial   = {rem_q, quo_q[DIV_W-1]};
  assign qbit    = trial >= divisor;
  assign rem_d   = qbit ? CNT_W'(trial - divisor) : CNT_W'(trial);
  assign mag     = quo_q[MEAN_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mean) begin
      quo_q <= DIV_W'(sum_mag);
      rem_q <= '0;
      neg_q <= sum_q[SUM_W-1];
    end else if (cmd_i.load_ms) begin
      quo_q <= sq_acc_q;
      rem_q <= '0;
      if (count_q == '0) begin
        mean_q <= '0;
      end else begin
        mean_q <= neg_q ? (~mag + MEAN_W'(1)) : mag;
      end
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DIV_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  // square root, two radicand bits per cycle
  assign srem_sh = {srem_q[SREM_W-3:0], x_q[RAD_W-1:RAD_W-2]};
  assign rtrial  = {1'b0, root_q, 2'b01};
  assign rbit    = srem_sh >= rtrial;
  assign srem_d  = rbit ? (srem_sh - rtrial) : srem_sh;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_root) begin
      x_q    <= (count_q == '0) ? '0 : RAD_W'(quo_q[SQ_W-1:0]);
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      x_q    <= {x_q[RAD_W-3:0], 2'b00};
      srem_q <= srem_d;
      root_q <= {root_q[ROOT_W-2:0], rbit};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.min_value    <= low_q;
      out_q.min_index    <= low_idx_q;
      out_q.max_value    <= high_q;
      out_q.max_index    <= high_idx_q;
      out_q.mean         <= mean_q;
      out_q.rms          <= root_q[ROOT_W-1] ? '1 : root_q[RMS_W-1:0];
      out_q.power        <= POWER_W'(pwr_q);
      out_q.sample_count <= COUNT_W'(count_q);
      out_q.too_long     <= ovf_q;
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

>>> src/q15_block_statistics_core.sv
// channel  dir  modport  payload     word accepted when
// in_i     in   sink     in_item_t   in_i.valid && in_i.ready
// out_o    out  source   out_item_t  out_o.valid && out_o.ready
//
// one sample word per cycle while a block is open; in_i.ready drops after the
// word that carries last and stays low until the statistics are done: two
// DW-step divisions (DW = 30 + count width) and a 16-step square root on one
// shared iteration counter
// the result sits in an output register, so the next block streams in while
// it waits; a finished block waits only if the previous result is still held
// rst_ni is asynchronous and clears all accumulators and the handshake state
`default_nettype none

module q15_block_statistics_core
  import qbs_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  qbs_stream_if.sink    in_i,
  qbs_stream_if.source  out_o
);

  cmd_t      cmd;
  out_item_t out_item;
  in_item_t  in_item;
  logic      in_ready;
  logic      out_valid;

  assign in_item = in_i.payload;

  qbs_ctrl #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_item.last),
    .in_ready_o (in_ready),
    .out_ready_i(out_o.ready),
    .out_valid_o(out_valid),
    .cmd_o      (cmd)
  );

  qbs_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_item_i (in_item),
    .out_item_o(out_item)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

  // a block end closes the input until the statistics are done
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready && in_item.last) |=> !in_ready)
    else $error("input accepted right after block end");

  // a new result never overwrites one that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid || out_o.ready))
    else $error("result register overwritten");

  // every result covers at least one sample
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> (out_o.payload.sample_count != '0))
    else $error("result with empty block");

  // minimum never exceeds maximum
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> (out_o.payload.min_value <= out_o.payload.max_value))
    else $error("minimum above maximum");

endmodule

`default_nettype wire

>>> dv/q15_block_statistics_core_test.sv
`timescale 1ns / 100ps

module q15_block_statistics_core_test;
  import qbs_pkg::*;

  localparam int unsigned CAPACITY = MAX_SAMPLES_DEF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam int unsigned RANDOM_WORDS = 800;
  localparam int unsigned IDLE_LIMIT = 2000;
  // two divisions plus the root, with margin
  localparam int unsigned TAIL_CYCLES = 250;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    bit                         typed;
    out_item_t                  want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  qbs_stream_if #(.payload_t(in_item_t))  in_ch ();
  qbs_stream_if #(.payload_t(out_item_t)) out_ch ();

  q15_block_statistics_core #(
    .MAX_SAMPLES(CAPACITY)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  // running block statistics as the block should hold them
  logic [COUNT_W-1:0]         blk_count;
  logic signed [SAMPLE_W-1:0] blk_low;
  logic [IDX_W-1:0]           blk_low_pos;
  logic signed [SAMPLE_W-1:0] blk_high;
  logic [IDX_W-1:0]           blk_high_pos;
  logic signed [27:0]         blk_sum;
  logic [42:0]                blk_sq_sum;
  logic [POWER_W-1:0]         blk_power;
  logic                       blk_spilled;

  out_item_t stats_due[$];
  stim_row_t stim_rows[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned burst_left;
  out_item_t got_stats;
  out_item_t want_stats;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    // radicand stays below 2^31, so the root fits in 17 bits
    for (int b = 16; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  task automatic clear_block();
    blk_count    = '0;
    blk_low      = '0;
    blk_low_pos  = '0;
    blk_high     = '0;
    blk_high_pos = '0;
    blk_sum      = '0;
    blk_sq_sum   = '0;
    blk_power    = '0;
    blk_spilled  = 1'b0;
  endtask

  task automatic fold_sample(input logic signed [SAMPLE_W-1:0] s, input logic l,
                             output bit done, output out_item_t res);
    longint sq;
    longint term;
    longint avg;
    longint unsigned root;
    done = 1'b0;
    res  = '0;
    if (blk_count < CAPACITY) begin
      sq   = longint'(s) * longint'(s);
      term = sq >>> TERM_SHIFT;
      if (term > 32767) term = 32767;
      // strict compare keeps the first position on ties
      if (blk_count == 0 || s < blk_low) begin
        blk_low     = s;
        blk_low_pos = blk_count[IDX_W-1:0];
      end
      if (blk_count == 0 || s > blk_high) begin
        blk_high     = s;
        blk_high_pos = blk_count[IDX_W-1:0];
      end
      blk_sum    = blk_sum + s;
      blk_sq_sum = blk_sq_sum + 43'(sq);
      blk_power  = blk_power + POWER_W'(term);
      blk_count  = blk_count + 1'b1;
    end else begin
      blk_spilled = 1'b1;
    end
    if (l) begin
      avg  = 0;
      root = 0;
      if (blk_count != 0) begin
        avg  = longint'(blk_sum) / longint'(blk_count);
        root = floor_root(longint'(blk_sq_sum) / longint'(blk_count));
        if (root > 32767) root = 32767;
      end
      res.min_value    = blk_low;
      res.min_index    = blk_low_pos;
      res.max_value    = blk_high;
      res.max_index    = blk_high_pos;
      res.mean         = avg[MEAN_W-1:0];
      res.rms          = root[RMS_W-1:0];
      res.power        = blk_power;
      res.sample_count = blk_count;
      res.too_long     = blk_spilled;
      done = 1'b1;
      clear_block();
    end
  endtask

  task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic l,
                           input bit typed, input out_item_t want);
    in_item_t w;
    bit done;
    out_item_t res;
    w.sample = s;
    w.last   = l;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.payload <= w;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    fold_sample(s, l, done, res);
    if (done) stats_due.push_back(typed ? want : res);
  endtask

  // bursts of random length with random gaps between them
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                        : $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (stats_due.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(input logic signed [SAMPLE_W-1:0] s, input logic l);
    stim_row_t r;
    r.sample = s;
    r.last   = l;
    r.typed  = 1'b0;
    r.want   = '0;
    stim_rows.push_back(r);
  endtask

  // a one-word block: every field follows from the sample itself
  task automatic add_single(input logic signed [SAMPLE_W-1:0] s,
                            input logic [RMS_W-1:0] rms, input logic [POWER_W-1:0] pwr);
    stim_row_t r;
    r.sample = s;
    r.last   = 1'b1;
    r.typed  = 1'b1;
    r.want   = '{min_value: s, min_index: '0, max_value: s, max_index: '0,
                 mean: s, rms: rms, power: pwr, sample_count: 13'd1,
                 too_long: 1'b0};
    stim_rows.push_back(r);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(
      input logic signed [SAMPLE_W-1:0] prev);
    int v;
    case ($urandom_range(0, 9))
      4: begin
        case ($urandom_range(0, 4))
          0: v = int'(SAMPLE_MIN);
          1: v = int'(SAMPLE_MAX);
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      5, 6: v = int'($urandom_range(0, 200)) - 100;
      7: v = int'(prev);
      8: v = int'(prev) - 1;
      default: v = $urandom_range(0, 65535);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic int unsigned pick_block_len();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return $urandom_range(1, 8);
    if (roll < 19) return $urandom_range(9, 64);
    return $urandom_range(65, 300);
  endfunction

  // receiver stalls on a pattern that cycles through four modes
  initial begin
    int unsigned cyc;
    out_ch.ready = 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      case ((cyc / 400) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ((cyc % 23) >= 8);
        default: out_ch.ready <= ((cyc % 150) >= 60);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (stats_due.size() == 0) begin
        report_error("result word with no block pending");
      end else begin
        want_stats = stats_due.pop_front();
        got_stats  = out_ch.payload;
        if (got_stats.min_value !== want_stats.min_value)
          report_error($sformatf("min_value got %0d want %0d",
                                 got_stats.min_value, want_stats.min_value));
        if (got_stats.min_index !== want_stats.min_index)
          report_error($sformatf("min_index got %0d want %0d",
                                 got_stats.min_index, want_stats.min_index));
        if (got_stats.max_value !== want_stats.max_value)
          report_error($sformatf("max_value got %0d want %0d",
                                 got_stats.max_value, want_stats.max_value));
        if (got_stats.max_index !== want_stats.max_index)
          report_error($sformatf("max_index got %0d want %0d",
                                 got_stats.max_index, want_stats.max_index));
        if (got_stats.mean !== want_stats.mean)
          report_error($sformatf("mean got %0d want %0d",
                                 got_stats.mean, want_stats.mean));
        if (got_stats.rms !== want_stats.rms)
          report_error($sformatf("rms got %0d want %0d",
                                 got_stats.rms, want_stats.rms));
        if (got_stats.power !== want_stats.power)
          report_error($sformatf("power got %0d want %0d",
                                 got_stats.power, want_stats.power));
        if (got_stats.sample_count !== want_stats.sample_count)
          report_error($sformatf("sample_count got %0d want %0d",
                                 got_stats.sample_count, want_stats.sample_count));
        if (got_stats.too_long !== want_stats.too_long)
          report_error($sformatf("too_long got %0d want %0d",
                                 got_stats.too_long, want_stats.too_long));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned next_hold;
    int unsigned len;
    int v;
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] prev;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    error_count   = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    clear_block();

    add_single(SAMPLE_MAX, 15'd32767, 27'd32766);
    // full-scale negative saturates both the power term and the rms
    add_single(SAMPLE_MIN, 15'd32767, 27'd32767);
    add_single(16'sd0, 15'd0, 27'd0);
    add_single(16'sd1, 15'd1, 27'd0);
    add_single(-16'sd1, 15'd1, 27'd0);
    add_single(16'sd182, 15'd182, 27'd1);
    // ties keep the earlier position
    add_row(16'sd5, 1'b0);
    add_row(-16'sd3, 1'b0);
    add_row(16'sd5, 1'b0);
    add_row(-16'sd3, 1'b1);
    // mean truncates toward zero on both signs
    add_row(-16'sd3, 1'b0);
    add_row(-16'sd4, 1'b1);
    add_row(16'sd3, 1'b0);
    add_row(16'sd4, 1'b1);
    add_row(SAMPLE_MIN, 1'b0);
    add_row(SAMPLE_MIN, 1'b0);
    add_row(SAMPLE_MAX, 1'b1);
    add_row(16'sh5555, 1'b0);
    add_row(16'shAAAA, 1'b1);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      send_word(stim_rows[i].sample, stim_rows[i].last, stim_rows[i].typed,
                stim_rows[i].want);
      pace_sender();
    end
    hold_until_drained();

    // exactly full block at full-scale negative: largest sums and power
    for (int i = 0; i < CAPACITY; i++) begin
      send_word(SAMPLE_MIN, i == CAPACITY - 1, 1'b0, '0);
      pace_sender();
    end
    // overrun block: max lands on the last counted position, the extra words
    // are ignored and the last mark rides on an ignored word
    for (int i = 0; i < CAPACITY + 3; i++) begin
      v = int'($urandom_range(0, 65533)) - 32767;
      if (i == CAPACITY - 1) s = SAMPLE_MAX;
      else if (i >= CAPACITY) s = SAMPLE_MIN;
      else s = v[SAMPLE_W-1:0];
      send_word(s, i == CAPACITY + 2, 1'b0, '0);
      pace_sender();
    end
    hold_until_drained();

    sent      = 0;
    next_hold = 250;
    prev      = '0;
    while (sent < RANDOM_WORDS) begin
      len = pick_block_len();
      for (int i = 0; i < len; i++) begin
        s = pick_sample(prev);
        send_word(s, i == len - 1, 1'b0, '0);
        prev = s;
        sent++;
        pace_sender();
      end
      if (sent >= next_hold) begin
        hold_until_drained();
        next_hold += 250;
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && stats_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
